### rtl/utf8_tagged_text_decoder_macros.svh
// assertion macros for the utf8 tagged text decoder
// used by modules that carry concurrent assertions; expects clk and rst_n in scope
`ifndef UTF8_TAGGED_TEXT_DECODER_MACROS_SVH
`define UTF8_TAGGED_TEXT_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define UTD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utd assertion failed");

// next-cycle implication, checked out of reset
`define UTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utd assertion failed");

`endif

### rtl/utd_pkg.sv
// types and constants shared by the utf8 tagged text decoder
// no dependencies
`default_nettype none

package utd_pkg;

    localparam logic [7:0] BYTE_TAG2_LO  = 8'h17;
    localparam logic [7:0] BYTE_TAG2_HI  = 8'h1e;
    localparam logic [7:0] BYTE_TAG1     = 8'h1f;
    localparam logic [7:0] BYTE_BAR      = 8'h7c;
    localparam logic [7:0] BYTE_LEAD3    = 8'he0;
    localparam logic [7:0] BYTE_LEAD4    = 8'hf0;
    localparam logic [7:0] BYTE_ZWNJ_LD  = 8'he2;
    localparam logic [7:0] BYTE_ZWNJ_MID = 8'h80;
    localparam logic [7:0] BYTE_ZWNJ_END = 8'h8c;

    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_TAG2  = 3'd1;
    localparam logic [2:0] CLS_TAG1  = 3'd2;
    localparam logic [2:0] CLS_BAR   = 3'd3;
    localparam logic [2:0] CLS_LEAD2 = 3'd4;
    localparam logic [2:0] CLS_LEAD3 = 3'd5;
    localparam logic [2:0] CLS_LEAD4 = 3'd6;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic tags;
        logic escapes;
    } utd_cfg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [2:0] cls;
        logic       stray;
        logic       zwnj_lead;
        logic       zwnj_mid;
        logic       zwnj_end;
    } utd_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [3:0]  byte_count;
        logic        status;
    } utd_result_t;

endpackage

`default_nettype wire

### rtl/utd_front.sv
// front end: accepts text bytes, classifies them and holds them in a two-entry queue
// depends on utd_pkg
`default_nettype none

module utd_front
    import utd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire utd_cfg_t  cfg,
    input  wire logic      push,
    output logic           full,
    input  wire logic [7:0] text_byte,
    output logic           item_valid,
    output utd_item_t      item,
    input  wire logic      item_take
);

    utd_item_t   slot0_reg, slot0_next;
    utd_item_t   slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;
    utd_item_t   cls_item;
    logic        push_ok;

    always_comb
    begin
        cls_item           = '0;
        cls_item.text_byte = text_byte;
        cls_item.stray     = (text_byte[7:6] == 2'b10);
        cls_item.zwnj_lead = (text_byte == BYTE_ZWNJ_LD);
        cls_item.zwnj_mid  = (text_byte == BYTE_ZWNJ_MID);
        cls_item.zwnj_end  = (text_byte == BYTE_ZWNJ_END);
        priority if (!text_byte[7])
        begin
            priority if (cfg.tags && text_byte >= BYTE_TAG2_LO && text_byte <= BYTE_TAG2_HI)
                cls_item.cls = CLS_TAG2;
            else if (cfg.tags && text_byte == BYTE_TAG1)
                cls_item.cls = CLS_TAG1;
            else if (cfg.tags && cfg.escapes && text_byte == BYTE_BAR)
                cls_item.cls = CLS_BAR;
            else
                cls_item.cls = CLS_ASCII;
        end
        else if (text_byte < BYTE_LEAD3)
            cls_item.cls = CLS_LEAD2;
        else if (text_byte < BYTE_LEAD4)
            cls_item.cls = CLS_LEAD3;
        else
            cls_item.cls = CLS_LEAD4;
    end

    assign full       = (count_reg == 2'd2);
    assign push_ok    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot0_reg;

    // slot0 is always the head
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case ({push_ok, item_take})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = cls_item;
                else
                    slot1_next = cls_item;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                    slot0_next = cls_item;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = cls_item;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### rtl/utd_back.sv
// back end: decoder state for sequences, tags, bars and non-joiners, plus a two-entry result queue
// depends on utd_pkg and utf8_tagged_text_decoder_macros.svh
`default_nettype none

`include "utf8_tagged_text_decoder_macros.svh"

module utd_back
    import utd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire utd_item_t  item,
    output logic            item_take,
    output logic            empty,
    input  wire logic       pop,
    output utd_result_t     result
);

    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [20:0] acc_reg, acc_next;
    logic [3:0]  prefix_count_reg, prefix_count_next;
    logic        bar_pending_reg, bar_pending_next;
    logic [1:0]  zwnj_reg, zwnj_next;
    logic [1:0]  payload_skip_reg, payload_skip_next;
    logic        stray_reg, stray_next;

    utd_result_t slot0_reg, slot0_next;
    utd_result_t slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    logic        emit;
    logic [20:0] emit_cp;
    logic [3:0]  count_inc;
    logic        pop_ok;
    logic        res_push;
    utd_result_t new_res;

    assign item_take = item_valid && (count_reg != 2'd2);
    assign count_inc = (prefix_count_reg == COUNT_MAX) ? prefix_count_reg
                                                       : prefix_count_reg + 4'd1;

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        acc_next          = acc_reg;
        prefix_count_next = count_inc;
        bar_pending_next  = bar_pending_reg;
        zwnj_next         = zwnj_reg;
        payload_skip_next = payload_skip_reg;
        stray_next        = stray_reg;
        emit              = 1'b0;
        emit_cp           = acc_reg;
        priority if (payload_skip_reg != 2'd0)
        begin
            payload_skip_next = payload_skip_reg - 2'd1;
            if (payload_skip_next == 2'd0)
                emit = 1'b1;
        end
        else if (bytes_left_reg != 2'd0)
        begin
            acc_next        = {acc_reg[14:0], item.text_byte[5:0]};
            emit_cp         = acc_next;
            bytes_left_next = bytes_left_reg - 2'd1;
            if (zwnj_reg == 2'd1)
                zwnj_next = item.zwnj_mid ? 2'd2 : 2'd0;
            else if (zwnj_reg == 2'd2)
                zwnj_next = item.zwnj_end ? 2'd3 : 2'd0;
            if (bytes_left_next == 2'd0)
            begin
                if (zwnj_next == 2'd3)
                begin
                    // non-joiner absorbed, its bytes stay in the running count
                    zwnj_next = 2'd0;
                    acc_next  = '0;
                end
                else
                    emit = 1'b1;
            end
        end
        else
        begin
            unique case (item.cls)
                CLS_TAG2, CLS_TAG1:
                begin
                    bar_pending_next  = 1'b0;
                    acc_next          = {13'd0, item.text_byte};
                    payload_skip_next = (item.cls == CLS_TAG2) ? 2'd2 : 2'd1;
                end
                CLS_BAR:
                begin
                    emit_cp = {13'd0, BYTE_BAR};
                    if (bar_pending_reg)
                        emit = 1'b1;
                    else
                        bar_pending_next = 1'b1;
                end
                CLS_ASCII:
                begin
                    emit_cp = {13'd0, item.text_byte};
                    emit    = 1'b1;
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
                begin
                    bar_pending_next = 1'b0;
                    stray_next       = item.stray;
                    zwnj_next        = item.zwnj_lead ? 2'd1 : 2'd0;
                    if (item.cls == CLS_LEAD2)
                    begin
                        acc_next        = {16'd0, item.text_byte[4:0]};
                        bytes_left_next = 2'd1;
                    end
                    else if (item.cls == CLS_LEAD3)
                    begin
                        acc_next        = {17'd0, item.text_byte[3:0]};
                        bytes_left_next = 2'd2;
                    end
                    else
                    begin
                        acc_next        = {18'd0, item.text_byte[2:0]};
                        bytes_left_next = 2'd3;
                    end
                end
                default:
                begin
                    emit_cp = {13'd0, item.text_byte};
                    emit    = 1'b1;
                end
            endcase
        end
        if (emit)
        begin
            bytes_left_next   = 2'd0;
            acc_next          = '0;
            prefix_count_next = 4'd0;
            bar_pending_next  = 1'b0;
            zwnj_next         = 2'd0;
            payload_skip_next = 2'd0;
            stray_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= 2'd0;
            acc_reg          <= '0;
            prefix_count_reg <= 4'd0;
            bar_pending_reg  <= 1'b0;
            zwnj_reg         <= 2'd0;
            payload_skip_reg <= 2'd0;
            stray_reg        <= 1'b0;
        end
        else if (item_take)
        begin
            bytes_left_reg   <= bytes_left_next;
            acc_reg          <= acc_next;
            prefix_count_reg <= prefix_count_next;
            bar_pending_reg  <= bar_pending_next;
            zwnj_reg         <= zwnj_next;
            payload_skip_reg <= payload_skip_next;
            stray_reg        <= stray_next;
        end
    end

    // result queue, slot0 is the head
    assign new_res.code_point = emit_cp;
    assign new_res.byte_count = count_inc;
    assign new_res.status     = stray_reg;
    assign res_push           = item_take && emit;
    assign empty              = (count_reg == 2'd0);
    assign pop_ok             = pop && !empty;
    assign result             = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case ({res_push, pop_ok})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = new_res;
                else
                    slot1_next = new_res;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                    slot0_next = new_res;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = new_res;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `UTD_ASSERT_IMPL(a_skip_excl_seq, bytes_left_reg != 2'd0, payload_skip_reg == 2'd0)
    `UTD_ASSERT_IMPL(a_no_result_overflow, res_push, count_reg != 2'd2)
    `UTD_ASSERT_IMPL(a_count_nonzero, !empty, result.byte_count != 4'd0)
    `UTD_ASSERT_NEXT(a_state_cleared, res_push,
                     prefix_count_reg == 4'd0 && bytes_left_reg == 2'd0 && !bar_pending_reg)

endmodule

`default_nettype wire

### rtl/utf8_tagged_text_decoder.sv
// a byte accepted into the front queue is held there until the back end takes and decodes
// it; when the decode emits a result, it enters the result queue and empty falls.
// throughput: one byte per cycle while the consumer pops at that rate. reset: rst_n
// asynchronous active low; queues empty, sequence state cleared, tags and escapes enabled.
// top level: config registers, front classifier/queue and back decoder; depends on utd_pkg
`default_nettype none

module utf8_tagged_text_decoder
    import utd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      code_point,
    output logic [3:0]       byte_count,
    output logic             status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    localparam logic REG_TAGS    = 1'b0;
    localparam logic REG_ESCAPES = 1'b1;

    utd_cfg_t    cfg_reg;
    logic        item_valid;
    logic        item_take;
    utd_item_t   item;
    utd_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tags    <= 1'b1;
            cfg_reg.escapes <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TAGS:    cfg_reg.tags    <= cfg_data;
                REG_ESCAPES: cfg_reg.escapes <= cfg_data;
                default:     cfg_reg.tags    <= cfg_reg.tags;
            endcase
        end
    end

    utd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    utd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign code_point = result.code_point;
    assign byte_count = result.byte_count;
    assign status     = result.status;

endmodule

`default_nettype wire
